// ----- rtl/mi3_pkg.sv -----
// Package for the 3x3 matrix inverse: widths, payload structs, cofactor product table.
package mi3_pkg;

  localparam int ELEM_W   = 32;
  localparam int FRAC_DEF = 16;
  localparam int NUM_EL   = 9;
  localparam int NUM_PROD = 2 * NUM_EL;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int COF_W    = 2 * ELEM_W + 1;
  localparam int PP_W     = 2 * ELEM_W + 1;
  localparam int DET_W    = 3 * ELEM_W + 3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic        [DET_W-1:0]  det_mag_t;

  typedef struct packed {
    elem_t a_r0c0;
    elem_t a_r0c1;
    elem_t a_r0c2;
    elem_t a_r1c0;
    elem_t a_r1c1;
    elem_t a_r1c2;
    elem_t a_r2c0;
    elem_t a_r2c1;
    elem_t a_r2c2;
  } in_t;

  typedef struct packed {
    elem_t inv_r0c0;
    elem_t inv_r0c1;
    elem_t inv_r0c2;
    elem_t inv_r1c0;
    elem_t inv_r1c1;
    elem_t inv_r1c2;
    elem_t inv_r2c0;
    elem_t inv_r2c1;
    elem_t inv_r2c2;
    logic  singular;
  } out_t;

  // adjugate element k = a[MUL_L[2k]]*a[MUL_R[2k]] - a[MUL_L[2k+1]]*a[MUL_R[2k+1]]
  localparam int unsigned MUL_L [NUM_PROD] =
    '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned MUL_R [NUM_PROD] =
    '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  // adjugate elements that pair with row 0 in the determinant expansion
  localparam int unsigned DET_COF [3] = '{0, 3, 6};

endpackage

// ----- rtl/mi3_cof.sv -----
// Cofactor stages: eighteen products, then nine adjugate differences.
module mi3_cof import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  in_t   in_data,
  output logic  cof_valid,
  output cof_t  cof [NUM_EL],
  output elem_t row0 [3]
);

  elem_t a [NUM_EL];
  logic signed [PROD_W-1:0] prod_r [NUM_PROD];
  elem_t row0_r [3];
  elem_t row0_rr [3];
  cof_t  cof_r [NUM_EL];
  logic  v1_r, v2_r;

  assign a[0] = in_data.a_r0c0;
  assign a[1] = in_data.a_r0c1;
  assign a[2] = in_data.a_r0c2;
  assign a[3] = in_data.a_r1c0;
  assign a[4] = in_data.a_r1c1;
  assign a[5] = in_data.a_r1c2;
  assign a[6] = in_data.a_r2c0;
  assign a[7] = in_data.a_r2c1;
  assign a[8] = in_data.a_r2c2;

  for (genvar p = 0; p < NUM_PROD; p++) begin : g_prod
    always_ff @(posedge clk) begin
      prod_r[p] <= PROD_W'(a[MUL_L[p]]) * PROD_W'(a[MUL_R[p]]);
    end
  end

  for (genvar k = 0; k < NUM_EL; k++) begin : g_cof
    always_ff @(posedge clk) begin
      cof_r[k] <= COF_W'(prod_r[2*k]) - COF_W'(prod_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    row0_r  <= '{a[0], a[1], a[2]};
    row0_rr <= row0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign cof_valid = v2_r;
  assign cof       = cof_r;
  assign row0      = row0_rr;

endmodule

// ----- rtl/mi3_det.sv -----
// Determinant stages: split partial products, sum, then signs and magnitudes.
module mi3_det import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cof_valid,
  input  cof_t     cof [NUM_EL],
  input  elem_t    row0 [3],
  output logic     mag_valid,
  output logic [COF_W+2*FRAC_BITS-1:0] num [NUM_EL],
  output det_mag_t den,
  output logic     neg [NUM_EL],
  output logic     sing
);

  localparam int NUM_W = COF_W + 2 * FRAC_BITS;

  logic signed [PP_W-1:0] lo_r [3];
  logic signed [PP_W-1:0] hi_r [3];
  cof_t  cof3_r [NUM_EL];
  cof_t  cof4_r [NUM_EL];
  det_t  det_r;
  det_t  det_nxt;
  logic [NUM_W-1:0] num_r [NUM_EL];
  det_mag_t den_r;
  logic  neg_r [NUM_EL];
  logic  sing_r;
  logic  v3_r, v4_r, v5_r;

  // row0 element times the low half (unsigned) and high half (signed) of its cofactor
  for (genvar j = 0; j < 3; j++) begin : g_pp
    logic signed [ELEM_W:0] lo_s;
    logic signed [ELEM_W:0] hi_s;
    assign lo_s = $signed({1'b0, cof[DET_COF[j]][ELEM_W-1:0]});
    assign hi_s = $signed(cof[DET_COF[j]][COF_W-1:ELEM_W]);
    always_ff @(posedge clk) begin
      lo_r[j] <= PP_W'(row0[j]) * PP_W'(lo_s);
      hi_r[j] <= PP_W'(row0[j]) * PP_W'(hi_s);
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DET_W'(hi_r[j]) <<< ELEM_W) + DET_W'(lo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    cof3_r <= cof;
    cof4_r <= cof3_r;
    det_r  <= det_nxt;
  end

  for (genvar k = 0; k < NUM_EL; k++) begin : g_mag
    logic [COF_W-1:0] cmag;
    assign cmag = cof4_r[k][COF_W-1] ? COF_W'(-cof4_r[k]) : COF_W'(cof4_r[k]);
    always_ff @(posedge clk) begin
      num_r[k] <= NUM_W'(cmag) << (2 * FRAC_BITS);
      neg_r[k] <= cof4_r[k][COF_W-1] ^ det_r[DET_W-1];
    end
  end

  always_ff @(posedge clk) begin
    den_r  <= det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    sing_r <= (det_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= cof_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign mag_valid = v5_r;
  assign num       = num_r;
  assign den       = den_r;
  assign neg       = neg_r;
  assign sing      = sing_r;

endmodule

// ----- rtl/mi3_div.sv -----
// Nine-lane restoring divider, one quotient bit per stage, with overflow pre-check.
module mi3_div import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     mag_valid,
  input  logic [COF_W+2*FRAC_BITS-1:0] num [NUM_EL],
  input  det_mag_t den,
  input  logic     neg [NUM_EL],
  input  logic     sing,
  output logic     q_valid,
  output logic [ELEM_W-1:0] quo [NUM_EL],
  output logic     q_ovf [NUM_EL],
  output logic     q_neg [NUM_EL],
  output logic     q_sing
);

  localparam int NUM_W = COF_W + 2 * FRAC_BITS;
  localparam int REM_W = (NUM_W > DET_W + ELEM_W) ? NUM_W : DET_W + ELEM_W;

  logic [REM_W-1:0]  rem_r [ELEM_W+1][NUM_EL];
  logic [ELEM_W-1:0] q_r   [ELEM_W+1][NUM_EL];
  logic              ovf_r [ELEM_W+1][NUM_EL];
  logic              neg_r [ELEM_W+1][NUM_EL];
  det_mag_t          d_r   [ELEM_W+1];
  logic              sing_r [ELEM_W+1];
  logic              vld_r  [ELEM_W+1];

  // entry stage: a quotient of 2^W or more saturates whatever its sign
  for (genvar k = 0; k < NUM_EL; k++) begin : g_pre
    logic [REM_W-1:0] lim_nxt;
    assign lim_nxt = REM_W'(den) << ELEM_W;
    always_ff @(posedge clk) begin
      rem_r[0][k] <= REM_W'(num[k]);
      q_r[0][k]   <= '0;
      ovf_r[0][k] <= REM_W'(num[k]) >= lim_nxt;
      neg_r[0][k] <= neg[k];
    end
  end

  always_ff @(posedge clk) begin
    d_r[0]    <= den;
    sing_r[0] <= sing;
  end

  for (genvar s = 1; s <= ELEM_W; s++) begin : g_st
    for (genvar k = 0; k < NUM_EL; k++) begin : g_el
      logic [REM_W-1:0] trial;
      logic             ge;
      assign trial = REM_W'(d_r[s-1]) << (ELEM_W - s);
      assign ge    = rem_r[s-1][k] >= trial;
      always_ff @(posedge clk) begin
        rem_r[s][k] <= ge ? rem_r[s-1][k] - trial : rem_r[s-1][k];
        q_r[s][k]   <= q_r[s-1][k] | (ELEM_W'(ge) << (ELEM_W - s));
        ovf_r[s][k] <= ovf_r[s-1][k];
        neg_r[s][k] <= neg_r[s-1][k];
      end
    end
    always_ff @(posedge clk) begin
      d_r[s]    <= d_r[s-1];
      sing_r[s] <= sing_r[s-1];
    end
  end

  for (genvar s = 0; s <= ELEM_W; s++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= (s == 0) ? mag_valid : vld_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign q_valid = vld_r[ELEM_W];
  assign quo     = q_r[ELEM_W];
  assign q_ovf   = ovf_r[ELEM_W];
  assign q_neg   = neg_r[ELEM_W];
  assign q_sing  = sing_r[ELEM_W];

endmodule

// ----- rtl/matrix3x3_inverse_top.sv -----
// Top level of the 3x3 matrix inverse: cofactors, determinant, divider, saturation.
//
//   channel   ports                      direction  transaction
//   input     start, busy, in_data       in         start && !busy
//   result    out_valid, out_data        out        out_valid, one cycle
//
// One matrix may enter every cycle while busy is low; its result passes the cofactor,
// determinant and divider stages, most of them in the one-bit-per-stage divider, and
// then the output register, which raises the strobe.
// busy is high only while rst_n is low. Reset clears the valid bits; data
// registers are not reset. The receiver cannot stall, so nothing ever holds.
module matrix3x3_inverse_top import mi3_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int NUM_W = COF_W + 2 * FRACTION_BITS;
  localparam int LAT   = ELEM_W + 7;
  localparam logic [ELEM_W-1:0] LIM = ELEM_W'(1) << (ELEM_W - 1);

  logic     cof_valid;
  cof_t     cof [NUM_EL];
  elem_t    row0 [3];
  logic     mag_valid;
  logic [NUM_W-1:0] num [NUM_EL];
  det_mag_t den;
  logic     neg [NUM_EL];
  logic     sing;
  logic     q_valid;
  logic [ELEM_W-1:0] quo [NUM_EL];
  logic     q_ovf [NUM_EL];
  logic     q_neg [NUM_EL];
  logic     q_sing;
  elem_t    res_nxt [NUM_EL];
  out_t     out_data_r;
  logic     out_valid_r;

  assign busy = ~rst_n;

  mi3_cof u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_data   (in_data),
    .cof_valid (cof_valid),
    .cof       (cof),
    .row0      (row0)
  );

  mi3_det #(.FRAC_BITS(FRACTION_BITS)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .cof_valid (cof_valid),
    .cof       (cof),
    .row0      (row0),
    .mag_valid (mag_valid),
    .num       (num),
    .den       (den),
    .neg       (neg),
    .sing      (sing)
  );

  mi3_div #(.FRAC_BITS(FRACTION_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .mag_valid (mag_valid),
    .num       (num),
    .den       (den),
    .neg       (neg),
    .sing      (sing),
    .q_valid   (q_valid),
    .quo       (quo),
    .q_ovf     (q_ovf),
    .q_neg     (q_neg),
    .q_sing    (q_sing)
  );

  // sign and saturate; a singular matrix gives zeros
  always_comb begin
    for (int k = 0; k < NUM_EL; k++) begin
      if (q_sing) begin
        res_nxt[k] = '0;
      end else if (q_neg[k]) begin
        res_nxt[k] = (q_ovf[k] || quo[k] > LIM) ? elem_t'(LIM) : elem_t'(-quo[k]);
      end else begin
        res_nxt[k] = (q_ovf[k] || quo[k] > LIM - 1'b1) ? elem_t'(LIM - 1'b1)
                                                       : elem_t'(quo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= '{res_nxt[0], res_nxt[1], res_nxt[2],
                    res_nxt[3], res_nxt[4], res_nxt[5],
                    res_nxt[6], res_nxt[7], res_nxt[8], q_sing};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted matrix did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching accepted matrix");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.inv_r0c0 == '0 && out_data.inv_r1c1 == '0 && out_data.inv_r2c2 == '0 &&
       out_data.inv_r0c1 == '0 && out_data.inv_r2c0 == '0))
    else $error("singular result with nonzero elements");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for matrix3x3_inverse_top: directed and random matrices, own predictor.
module testbench;
  import mi3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = ELEM_W + 7;
  localparam int STALL_MAX  = 5000;
  localparam int ELEM_MAX   = 32'h7fff_ffff;
  localparam int ELEM_MIN   = 32'h8000_0000;
  localparam int ONE_Q      = 1 << FRAC_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  out_t inverse_q[$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   quiet_cycles = 0;

  matrix3x3_inverse_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic elem_t quotient(logic signed [255:0] cof, logic signed [255:0] det);
    logic [255:0] n, d, q;
    logic neg;
    neg = (cof < 0) != (det < 0);
    n = (cof < 0) ? -cof : cof;
    d = (det < 0) ? -det : det;
    n = n << (2 * FRAC_DEF);
    q = n / d;
    if (neg) begin
      if (q > 256'h8000_0000) return elem_t'(ELEM_MIN);
      return elem_t'(-q[31:0]);
    end
    if (q > 256'h7fff_ffff) return elem_t'(ELEM_MAX);
    return elem_t'(q[31:0]);
  endfunction

  // adjugate over determinant, exact on 256-bit intermediates
  function automatic out_t invert(in_t m);
    logic signed [255:0] a [9];
    logic signed [255:0] c [9];
    logic signed [255:0] det;
    elem_t r [9];
    out_t o;
    a[0] = m.a_r0c0; a[1] = m.a_r0c1; a[2] = m.a_r0c2;
    a[3] = m.a_r1c0; a[4] = m.a_r1c1; a[5] = m.a_r1c2;
    a[6] = m.a_r2c0; a[7] = m.a_r2c1; a[8] = m.a_r2c2;
    c[0] = a[4]*a[8] - a[5]*a[7];
    c[1] = a[2]*a[7] - a[1]*a[8];
    c[2] = a[1]*a[5] - a[2]*a[4];
    c[3] = a[5]*a[6] - a[3]*a[8];
    c[4] = a[0]*a[8] - a[2]*a[6];
    c[5] = a[2]*a[3] - a[0]*a[5];
    c[6] = a[3]*a[7] - a[4]*a[6];
    c[7] = a[1]*a[6] - a[0]*a[7];
    c[8] = a[0]*a[4] - a[1]*a[3];
    det = a[0]*c[0] + a[1]*c[3] + a[2]*c[6];
    for (int i = 0; i < 9; i++) r[i] = (det == 0) ? '0 : quotient(c[i], det);
    o.inv_r0c0 = r[0]; o.inv_r0c1 = r[1]; o.inv_r0c2 = r[2];
    o.inv_r1c0 = r[3]; o.inv_r1c1 = r[4]; o.inv_r1c2 = r[5];
    o.inv_r2c0 = r[6]; o.inv_r2c1 = r[7]; o.inv_r2c2 = r[8];
    o.singular = (det == 0);
    return o;
  endfunction

  // predict on each accepted transaction, check each result
  always @(posedge clk) begin
    out_t want;
    logic [ELEM_W-1:0] w [9];
    logic [ELEM_W-1:0] g [9];
    if (rst_n && start && !busy) inverse_q.push_back(invert(in_data));
    if (rst_n && out_valid) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = inverse_q.pop_front();
        {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]} = want[9*ELEM_W:1];
        {g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7], g[8]} = out_data[9*ELEM_W:1];
        for (int i = 0; i < 9; i++)
          if (w[i] !== g[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("inverse element %0d: expected %h got %h", i, w[i], g[i]);
          end
        if (want.singular !== out_data.singular) begin
          mismatches++;
          if (mismatches <= 10)
            $display("singular: expected %b got %b", want.singular, out_data.singular);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  // each cycle the sender idles with probability idle_pct percent
  task automatic send_matrix(input in_t m);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic in_t make_diag(elem_t d0, elem_t d1, elem_t d2);
    in_t m;
    m = '0;
    m.a_r0c0 = d0; m.a_r1c1 = d1; m.a_r2c2 = d2;
    return m;
  endfunction

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(1 << 19)) - (1 << 18));
      default: return elem_t'($signed($urandom_range(ONE_Q << 4)) - (ONE_Q << 3));
    endcase
  endfunction

  // kind 2: diagonal of magnitude ONE_Q/4 to 64*ONE_Q, off-diagonal terms within 8*ONE_Q
  function automatic in_t rand_matrix(int kind);
    elem_t e [9];
    for (int i = 0; i < 9; i++) e[i] = rand_elem(kind);
    if (kind == 2)
      for (int i = 0; i < 9; i += 4)
        e[i] = elem_t'($urandom_range(ONE_Q << 6, ONE_Q >> 2) * ($urandom_range(1) ? 1 : -1));
    return '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  task automatic test_directed();
    in_t m;
    send_matrix(make_diag(ONE_Q, ONE_Q, ONE_Q));
    send_matrix('0);
    send_matrix('1);
    send_matrix({9{elem_t'(ELEM_MAX)}});
    send_matrix({9{elem_t'(ELEM_MIN)}});
    send_matrix(make_diag(ELEM_MAX, ELEM_MAX, ELEM_MAX));
    send_matrix(make_diag(ELEM_MIN, ELEM_MIN, ELEM_MIN));
    send_matrix(make_diag(1, 1, 1));        // positive saturation
    send_matrix(make_diag(-1, 1, 1));       // negative saturation
    send_matrix(make_diag(ELEM_MIN, 1, 1));
    send_matrix(make_diag(2 * ONE_Q, -4 * ONE_Q, ONE_Q / 2));
    send_matrix(make_diag(3 * ONE_Q, 7 * ONE_Q, -ONE_Q));  // inexact quotients
    m = rand_matrix(2);
    m.a_r2c0 = m.a_r0c0; m.a_r2c1 = m.a_r0c1; m.a_r2c2 = m.a_r0c2;  // repeated row
    send_matrix(m);
    m = '{ONE_Q, 2*ONE_Q, 3*ONE_Q, 4*ONE_Q, 5*ONE_Q, 6*ONE_Q, 7*ONE_Q, 8*ONE_Q, 9*ONE_Q};
    send_matrix(m);
    m = '{0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0};           // permutation
    send_matrix(m);
    m = '{2*ONE_Q, 0, 0, 0, 3*ONE_Q, 0, 5*ONE_Q, 0, 7*ONE_Q}; // only the a00 term of the determinant in use
    send_matrix(m);
    send_matrix(make_diag(ONE_Q, 0, ONE_Q));
    wait_drained();
  endtask

  task automatic test_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(9);
      send_matrix(rand_matrix(r < 6 ? 2 : (r < 8 ? 1 : 0)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    idle_pct = 29;
    test_random(480);
    wait_drained();
    idle_pct = 75;
    test_random(480);
    wait_drained();
    idle_pct = 0;
    test_random(480);
    wait_drained();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mi3_pkg.sv
rtl/mi3_cof.sv
rtl/mi3_det.sv
rtl/mi3_div.sv
rtl/matrix3x3_inverse_top.sv
sim/testbench.sv
